>>> design/bb5_pkg.sv
// Shared types, constants and helper functions of the balanced base 5 encoder.
// No dependencies; every other design file imports this package.
`default_nettype none

package bb5_pkg;

	localparam int IN_BITS          = 64;
	localparam int DEF_VALUE_BITS   = 64;
	localparam int DEF_MAX_DIGITS   = 28;
	localparam int SLICE_BITS       = 8;
	localparam int QUEUE_DEPTH      = 2;

	localparam logic [2:0] RADIX     = 3'd5;
	localparam logic [2:0] CARRY_MIN = 3'd3;

	localparam logic [2:0] DIG_M2 = 3'b110;
	localparam logic [2:0] DIG_M1 = 3'b111;
	localparam logic [2:0] DIG_0  = 3'b000;
	localparam logic [2:0] DIG_P1 = 3'b001;
	localparam logic [2:0] DIG_P2 = 3'b010;

	localparam logic [6:0] CHAR_M2   = 7'h3D;
	localparam logic [6:0] CHAR_M1   = 7'h2D;
	localparam logic [6:0] CHAR_0    = 7'h30;
	localparam logic [6:0] CHAR_P1   = 7'h31;
	localparam logic [6:0] CHAR_P2   = 7'h32;
	localparam logic [6:0] CHAR_NONE = 7'h00;

	typedef struct packed {
		logic valid;
		logic none;
	} bb5_tag_t;

	function automatic logic [SLICE_BITS+2:0] div5_slice(input logic [2:0] rem_in,
			input logic [SLICE_BITS-1:0] bits);
		logic [3:0] acc;
		logic [2:0] r;
		logic [SLICE_BITS-1:0] q;
		r = rem_in;
		q = '0;
		for (int i = SLICE_BITS - 1; i >= 0; i--) begin
			acc = {r, bits[i]};
			if (acc >= {1'b0, RADIX}) begin
				q[i] = 1'b1;
				acc  = acc - {1'b0, RADIX};
			end else begin
				q[i] = 1'b0;
			end
			r = acc[2:0];
		end
		return {r, q};
	endfunction

	function automatic logic [6:0] char_of_digit(input logic [2:0] d);
		logic [6:0] c;
		unique case (d)
			DIG_M2:  c = CHAR_M2;
			DIG_M1:  c = CHAR_M1;
			DIG_0:   c = CHAR_0;
			DIG_P1:  c = CHAR_P1;
			DIG_P2:  c = CHAR_P2;
			default: c = CHAR_0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/bb5_front.sv
// Front stage: takes commands, masks the value and flags zero or negative input.
// Depends on bb5_pkg; feeds bb5_queue.
`default_nettype none

module bb5_front
	import bb5_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [IN_BITS-1:0]    value,
	input  wire logic                  queue_full,
	output bb5_tag_t                   push_tag,
	output logic [VALUE_BITS-1:0]      push_value
);

	logic                  valid_s1;
	logic                  none_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  accept;
	logic                  push;
	logic [VALUE_BITS-1:0] raw;

	assign raw    = value[VALUE_BITS-1:0];
	assign push   = valid_s1 && !queue_full;
	assign busy   = valid_s1 && queue_full;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= raw;
			none_s1  <= raw[VALUE_BITS-1] || (raw == '0);
		end
	end

	assign push_tag.valid = push;
	assign push_tag.none  = none_s1;
	assign push_value     = value_s1;

endmodule

`default_nettype wire

>>> design/bb5_queue.sv
// Two-entry queue between the front stage and the digit engine.
// Depends on bb5_pkg.
`default_nettype none

module bb5_queue
	import bb5_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bb5_tag_t              push_tag,
	input  wire logic [VALUE_BITS-1:0] push_value,
	output logic                       full,
	input  wire logic                  pop,
	output bb5_tag_t                   pop_tag,
	output logic [VALUE_BITS-1:0]      pop_value
);

	logic [VALUE_BITS-1:0] value_q [QUEUE_DEPTH];
	logic                  none_q  [QUEUE_DEPTH];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == 2'(QUEUE_DEPTH));
	assign do_push = push_tag.valid && !full;
	assign do_pop  = pop && (count_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			value_q[wr_ptr_q] <= push_value;
			none_q[wr_ptr_q]  <= push_tag.none;
		end
	end

	assign pop_tag.valid = (count_q != 2'd0);
	assign pop_tag.none  = none_q[rd_ptr_q];
	assign pop_value     = value_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> design/bb5_back.sv
// Digit engine: divides by 5 one slice per cycle, stores digits, emits them
// most significant first. Depends on bb5_pkg; drains bb5_queue.
`default_nettype none

module bb5_back
	import bb5_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bb5_tag_t              pop_tag,
	input  wire logic [VALUE_BITS-1:0] pop_value,
	output logic                       pop,
	output logic                       strobe,
	output logic [6:0]                 digit_char,
	output logic signed [2:0]          digit_value,
	output logic                       last_digit,
	output logic                       no_digits
);

	localparam int CHUNKS = (VALUE_BITS + SLICE_BITS - 1) / SLICE_BITS;
	localparam int PAD    = CHUNKS * SLICE_BITS;
	localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W  = $clog2(MAX_DIGITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIX  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic [PAD-1:0]        work_q;
	logic [2:0]            rem_q;
	logic [CHK_W-1:0]      chunk_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [2:0]            digit_store [MAX_DIGITS];

	logic [SLICE_BITS+2:0] slice;
	logic                  carry;
	logic [2:0]            digit;
	logic [PAD-1:0]        quot;
	logic                  run_done;

	assign pop      = (state_q == ST_IDLE) && pop_tag.valid;
	assign slice    = div5_slice(rem_q, work_q[PAD-1 -: SLICE_BITS]);
	assign carry    = (rem_q >= CARRY_MIN);
	assign digit    = carry ? 3'(rem_q - RADIX) : rem_q;
	assign quot     = work_q + PAD'(carry);
	assign run_done = (quot == '0) || (cnt_q + CNT_W'(1) == CNT_W'(MAX_DIGITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (pop_tag.none) begin
							strobe <= 1'b1;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (chunk_q == CHK_W'(CHUNKS - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					state_q <= run_done ? ST_EMIT : ST_DIV;
				end
				ST_EMIT: begin
					strobe <= 1'b1;
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				work_q      <= PAD'(pop_value);
				rem_q       <= 3'd0;
				chunk_q     <= '0;
				cnt_q       <= '0;
				digit_char  <= CHAR_NONE;
				digit_value <= DIG_0;
				last_digit  <= 1'b1;
				no_digits   <= 1'b1;
			end
			ST_DIV: begin
				work_q  <= (work_q << SLICE_BITS) | PAD'(slice[SLICE_BITS-1:0]);
				rem_q   <= slice[SLICE_BITS+2 -: 3];
				chunk_q <= chunk_q + CHK_W'(1);
			end
			ST_FIX: begin
				digit_store[cnt_q[IDX_W-1:0]] <= digit;
				work_q  <= quot;
				rem_q   <= 3'd0;
				chunk_q <= '0;
				cnt_q   <= cnt_q + CNT_W'(1);
				idx_q   <= cnt_q[IDX_W-1:0];
			end
			ST_EMIT: begin
				digit_char  <= char_of_digit(digit_store[idx_q]);
				digit_value <= digit_store[idx_q];
				last_digit  <= (idx_q == '0);
				no_digits   <= 1'b0;
				idx_q       <= idx_q - IDX_W'(1);
			end
			default: begin
				rem_q <= 3'd0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> design/balanced_base5_encoder_top.sv
// Balanced base 5 encoder top level: front stage, two-entry queue, digit engine.
// Depends on bb5_pkg, bb5_front, bb5_queue and bb5_back.
// Path: start is registered in the front stage, held in the queue and popped by the digit engine,
// which runs ST_DIV then ST_FIX for each digit and then ST_EMIT; results follow on consecutive cycles.
// Zero or negative input: one result. The engine takes a new item only once it is idle again,
// and its divide-by-5 unit retires one 8-bit slice per cycle while in ST_DIV.
// Reset: arst_n clears all control state asynchronously; the receiver cannot stall.
`default_nettype none

module balanced_base5_encoder_top
	import bb5_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [IN_BITS-1:0] value,
	output logic                    strobe,
	output logic [6:0]              digit_char,
	output logic signed [2:0]       digit_value,
	output logic                    last_digit,
	output logic                    no_digits
);

	bb5_tag_t              push_tag;
	bb5_tag_t              pop_tag;
	logic [VALUE_BITS-1:0] push_value;
	logic [VALUE_BITS-1:0] pop_value;
	logic                  queue_full;
	logic                  pop;

	bb5_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.queue_full(queue_full),
		.push_tag  (push_tag),
		.push_value(push_value)
	);

	bb5_queue #(
		.VALUE_BITS(VALUE_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_tag  (push_tag),
		.push_value(push_value),
		.full      (queue_full),
		.pop       (pop),
		.pop_tag   (pop_tag),
		.pop_value (pop_value)
	);

	bb5_back #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_DIGITS(MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_tag    (pop_tag),
		.pop_value  (pop_value),
		.pop        (pop),
		.strobe     (strobe),
		.digit_char (digit_char),
		.digit_value(digit_value),
		.last_digit (last_digit),
		.no_digits  (no_digits)
	);

	a_none_shape: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && no_digits |-> last_digit && digit_value == 3'sd0 && digit_char == CHAR_NONE)
		else $error("empty result malformed");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !no_digits |-> digit_value >= -3'sd2 && digit_value <= 3'sd2)
		else $error("digit out of range");

	a_char_match: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !no_digits |-> digit_char == char_of_digit(digit_value))
		else $error("digit character mismatch");

	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !no_digits && !last_digit |=> strobe && !no_digits)
		else $error("digit run broken");

endmodule

`default_nettype wire
